// ===== rtl/core/pld_pkg.sv =====
package pld_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int U_FRAC_BITS_DEF = 32;
    localparam int DIST_WIDTH      = 36;
    localparam int CFG_IDX_W       = 8;
    localparam int CFG_DATA_W      = 8;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DEGEN   = 2'd1,
        ST_OUTSIDE = 2'd2
    } t_status;

    localparam logic [1:0] LM_INFINITE = 2'd0;
    localparam logic [1:0] LM_CLAMP    = 2'd1;
    localparam logic [1:0] LM_CHECKED  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_MODE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 8'd1;

endpackage

// ===== rtl/core/point_line_distance_3d_top.sv =====
// Fully pipelined point-to-line distance, one request accepted every cycle (o_busy stays low).
// The pipeline from the accepting edge to the result strobe o_valid has 4 setup stages,
// one restoring divider stage per quotient bit (2*COORD_WIDTH + U_FRAC_BITS + 2), 7 product
// stages, one square root stage per root bit (COORD_WIDTH + 3) and the output register.
// The receiver cannot stall the pipeline.
// Synchronous active-low reset clears valid bits and config (line_mode = 0, signed_mode = 0).
module point_line_distance_3d_top #(
    parameter int COORD_WIDTH = pld_pkg::COORD_WIDTH_DEF,
    parameter int U_FRAC_BITS = pld_pkg::U_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic signed [COORD_WIDTH-1:0]       i_line_ax,
    input  logic signed [COORD_WIDTH-1:0]       i_line_ay,
    input  logic signed [COORD_WIDTH-1:0]       i_line_az,
    input  logic signed [COORD_WIDTH-1:0]       i_line_bx,
    input  logic signed [COORD_WIDTH-1:0]       i_line_by,
    input  logic signed [COORD_WIDTH-1:0]       i_line_bz,
    input  logic signed [COORD_WIDTH-1:0]       i_query_x,
    input  logic signed [COORD_WIDTH-1:0]       i_query_y,
    input  logic signed [COORD_WIDTH-1:0]       i_query_z,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pld_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pld_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_valid,
    output logic signed [pld_pkg::DIST_WIDTH-1:0] o_dist_res,
    output logic [1:0]                          o_status
);

    localparam int DW   = COORD_WIDTH + 1;            // differences
    localparam int LW   = 2 * COORD_WIDTH + 2;        // squared length, |dot|
    localparam int DSW  = LW + 1;                     // signed dot
    localparam int NW   = LW + U_FRAC_BITS;           // quotient bits
    localparam int RW   = LW + 1;                     // divider remainder
    localparam int EW   = COORD_WIDTH + U_FRAC_BITS + 3;
    localparam int EM   = EW - 1;
    localparam int UH   = EW / 2;
    localparam int UHW  = EW - UH;
    localparam int H2   = (EM + 1) / 2;
    localparam int EHW  = EM - H2;
    localparam int SQW  = 2 * EM;
    localparam int SW   = SQW + 2;
    localparam int TW   = SW - 2 * U_FRAC_BITS;
    localparam int RTW  = TW / 2;
    localparam int RRW  = RTW + 2;
    localparam int OW   = pld_pkg::DIST_WIDTH;
    localparam int MW   = (RTW > OW) ? RTW : OW;
    localparam logic [NW-1:0] U_ONE = NW'(1) << U_FRAC_BITS;
    localparam logic [MW-1:0] D_MAX = (MW'(1) << (OW - 1)) - MW'(1);

    logic [1:0] r_line_mode;
    logic       r_signed_mode;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_mode   <= pld_pkg::LM_INFINITE;
            r_signed_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == pld_pkg::CFG_LINE_MODE) begin
                r_line_mode <= i_cfg_data[1:0];
            end else if (i_cfg_index == pld_pkg::CFG_SIGNED_MODE) begin
                r_signed_mode <= i_cfg_data[0];
            end
        end
    end

    // ---------------- setup stages ----------------
    logic                  r_s1_v;
    logic signed [DW-1:0]  r_s1_d [3];
    logic signed [DW-1:0]  r_s1_w [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= i_start & ~o_busy;
        end
        r_s1_d[0] <= DW'(i_line_bx) - DW'(i_line_ax);
        r_s1_d[1] <= DW'(i_line_by) - DW'(i_line_ay);
        r_s1_d[2] <= DW'(i_line_bz) - DW'(i_line_az);
        r_s1_w[0] <= DW'(i_query_x) - DW'(i_line_ax);
        r_s1_w[1] <= DW'(i_query_y) - DW'(i_line_ay);
        r_s1_w[2] <= DW'(i_query_z) - DW'(i_line_az);
    end

    logic                   r_s2_v;
    logic                   r_s2_degen;
    logic signed [DW-1:0]   r_s2_d  [3];
    logic signed [DW-1:0]   r_s2_w  [3];
    logic signed [2*DW-1:0] r_s2_dd [3];
    logic signed [2*DW-1:0] r_s2_wd [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
        r_s2_degen <= (r_s1_d[0] == '0) && (r_s1_d[1] == '0) && (r_s1_d[2] == '0);
        for (int i = 0; i < 3; i++) begin
            r_s2_d[i]  <= r_s1_d[i];
            r_s2_w[i]  <= r_s1_w[i];
            r_s2_dd[i] <= r_s1_d[i] * r_s1_d[i];
            r_s2_wd[i] <= r_s1_w[i] * r_s1_d[i];
        end
    end

    logic                  r_s3_v;
    logic                  r_s3_degen;
    logic [LW-1:0]         r_s3_l;
    logic signed [DSW-1:0] r_s3_dot;
    logic signed [DW-1:0]  r_s3_d [3];
    logic signed [DW-1:0]  r_s3_w [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v;
        end
        r_s3_degen <= r_s2_degen;
        r_s3_l     <= LW'(r_s2_dd[0]) + LW'(r_s2_dd[1]) + LW'(r_s2_dd[2]);
        r_s3_dot   <= DSW'(r_s2_wd[0]) + DSW'(r_s2_wd[1]) + DSW'(r_s2_wd[2]);
        for (int i = 0; i < 3; i++) begin
            r_s3_d[i] <= r_s2_d[i];
            r_s3_w[i] <= r_s2_w[i];
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    logic                 r_dv_v     [0:NW];
    logic                 r_dv_degen [0:NW];
    logic                 r_dv_negd  [0:NW];
    logic [LW-1:0]        r_dv_absd  [0:NW];
    logic [LW-1:0]        r_dv_l     [0:NW];
    logic [RW-1:0]        r_dv_rem   [0:NW];
    logic [NW-1:0]        r_dv_q     [0:NW];
    logic signed [DW-1:0] r_dv_d     [0:NW][0:2];
    logic signed [DW-1:0] r_dv_w     [0:NW][0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else begin
            r_dv_v[0] <= r_s3_v;
        end
        r_dv_degen[0] <= r_s3_degen;
        r_dv_negd[0]  <= r_s3_dot[DSW-1];
        r_dv_absd[0]  <= r_s3_dot[DSW-1] ? LW'(-r_s3_dot) : LW'(r_s3_dot);
        r_dv_l[0]     <= r_s3_l;
        r_dv_rem[0]   <= '0;
        r_dv_q[0]     <= '0;
        for (int i = 0; i < 3; i++) begin
            r_dv_d[0][i] <= r_s3_d[i];
            r_dv_w[0][i] <= r_s3_w[i];
        end
    end

    for (genvar k = 0; k < NW; k++) begin : g_div
        localparam int B = NW - 1 - k;
        logic          nbit;
        logic [RW-1:0] rem2;
        logic          ge;

        // numerator is |dot| shifted up by the fraction bits
        if (B >= U_FRAC_BITS) begin : g_nbit
            assign nbit = r_dv_absd[k][B-U_FRAC_BITS];
        end else begin : g_zero
            assign nbit = 1'b0;
        end

        assign rem2 = {r_dv_rem[k][RW-2:0], nbit};
        assign ge   = rem2 >= {1'b0, r_dv_l[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
            r_dv_degen[k+1] <= r_dv_degen[k];
            r_dv_negd[k+1]  <= r_dv_negd[k];
            r_dv_absd[k+1]  <= r_dv_absd[k];
            r_dv_l[k+1]     <= r_dv_l[k];
            r_dv_rem[k+1]   <= ge ? (rem2 - {1'b0, r_dv_l[k]}) : rem2;
            r_dv_q[k+1]     <= r_dv_q[k] | (ge ? (NW'(1) << B) : '0);
            for (int i = 0; i < 3; i++) begin
                r_dv_d[k+1][i] <= r_dv_d[k][i];
                r_dv_w[k+1][i] <= r_dv_w[k][i];
            end
        end
    end

    // ---------------- projection parameter, mode handling ----------------
    logic                 u_neg_nz;
    logic                 u_gt_one;
    logic signed [NW:0]   u_val;
    logic signed [NW:0]   u_sel;
    logic                 u_outside;
    pld_pkg::t_status     u_status;

    assign u_neg_nz  = r_dv_negd[NW] && (r_dv_q[NW] != '0);
    assign u_gt_one  = !r_dv_negd[NW] && (r_dv_q[NW] > U_ONE);
    assign u_outside = u_neg_nz || u_gt_one;
    assign u_val     = r_dv_negd[NW] ? -$signed({1'b0, r_dv_q[NW]})
                                     : $signed({1'b0, r_dv_q[NW]});

    always_comb begin
        u_sel    = u_val;
        u_status = pld_pkg::ST_OK;
        case (r_line_mode)
            pld_pkg::LM_CLAMP: begin
                if (u_neg_nz) begin
                    u_sel = '0;
                end else if (u_gt_one) begin
                    u_sel = $signed({1'b0, U_ONE});
                end
            end
            pld_pkg::LM_CHECKED: begin
                if (u_outside) begin
                    u_status = pld_pkg::ST_OUTSIDE;
                end
            end
            default: begin
                u_sel = u_val;
            end
        endcase
        if (r_dv_degen[NW]) begin
            u_status = pld_pkg::ST_DEGEN;
        end
    end

    logic                 r_u_v;
    logic [EW-1:0]        r_u_ulo;
    pld_pkg::t_status     r_u_status;
    logic signed [DW-1:0] r_u_d [3];
    logic signed [DW-1:0] r_u_w [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_v <= 1'b0;
        end else begin
            r_u_v <= r_dv_v[NW];
        end
        r_u_ulo    <= u_sel[EW-1:0];
        r_u_status <= u_status;
        for (int i = 0; i < 3; i++) begin
            r_u_d[i] <= r_dv_d[NW][i];
            r_u_w[i] <= r_dv_w[NW][i];
        end
    end

    // ---------------- residual e = w*2^F - u*d, modulo 2^EW ----------------
    logic                        r_p1_v;
    pld_pkg::t_status            r_p1_status;
    logic                        r_p1_d0pos;
    logic                        r_p1_d0neg;
    logic signed [DW-1:0]        r_p1_w  [3];
    logic signed [UH+DW:0]       r_p1_pl [3];
    logic signed [UHW+DW:0]      r_p1_ph [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else begin
            r_p1_v <= r_u_v;
        end
        r_p1_status <= r_u_status;
        r_p1_d0neg  <= r_u_d[0][DW-1];
        r_p1_d0pos  <= !r_u_d[0][DW-1] && (r_u_d[0] != '0);
        for (int i = 0; i < 3; i++) begin
            r_p1_w[i]  <= r_u_w[i];
            r_p1_pl[i] <= $signed({1'b0, r_u_ulo[UH-1:0]}) * r_u_d[i];
            r_p1_ph[i] <= $signed({1'b0, r_u_ulo[EW-1:UH]}) * r_u_d[i];
        end
    end

    logic                 r_p2_v;
    pld_pkg::t_status     r_p2_status;
    logic                 r_p2_d0pos;
    logic                 r_p2_d0neg;
    logic signed [EW-1:0] r_p2_e [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else begin
            r_p2_v <= r_p1_v;
        end
        r_p2_status <= r_p1_status;
        r_p2_d0pos  <= r_p1_d0pos;
        r_p2_d0neg  <= r_p1_d0neg;
        for (int i = 0; i < 3; i++) begin
            r_p2_e[i] <= (EW'(r_p1_w[i]) <<< U_FRAC_BITS) - EW'(r_p1_pl[i])
                       - (EW'(r_p1_ph[i]) << UH);
        end
    end

    logic             n_a_neg;
    logic             r_a_v;
    logic             r_a_neg;
    pld_pkg::t_status r_a_status;
    logic [EM-1:0]    r_a_em [3];

    always_comb begin
        n_a_neg = 1'b0;
        if (r_signed_mode) begin
            if (r_p2_d0pos) begin
                n_a_neg = r_p2_e[1][EW-1];
            end else if (r_p2_d0neg) begin
                n_a_neg = !r_p2_e[1][EW-1];
            end else begin
                n_a_neg = r_p2_e[0][EW-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= r_p2_v;
        end
        r_a_neg    <= n_a_neg;
        r_a_status <= r_p2_status;
        for (int i = 0; i < 3; i++) begin
            r_a_em[i] <= r_p2_e[i][EW-1] ? EM'(-r_p2_e[i]) : EM'(r_p2_e[i]);
        end
    end

    // ---------------- squared norm from split partial products ----------------
    logic                   r_q1_v;
    logic                   r_q1_neg;
    pld_pkg::t_status       r_q1_status;
    logic [2*EHW-1:0]       r_q1_hh [3];
    logic [EHW+H2-1:0]      r_q1_hl [3];
    logic [2*H2-1:0]        r_q1_ll [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_v <= 1'b0;
        end else begin
            r_q1_v <= r_a_v;
        end
        r_q1_neg    <= r_a_neg;
        r_q1_status <= r_a_status;
        for (int i = 0; i < 3; i++) begin
            r_q1_hh[i] <= r_a_em[i][EM-1:H2] * r_a_em[i][EM-1:H2];
            r_q1_hl[i] <= r_a_em[i][EM-1:H2] * r_a_em[i][H2-1:0];
            r_q1_ll[i] <= r_a_em[i][H2-1:0] * r_a_em[i][H2-1:0];
        end
    end

    logic             r_q2_v;
    logic             r_q2_neg;
    pld_pkg::t_status r_q2_status;
    logic [SQW-1:0]   r_q2_sq [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q2_v <= 1'b0;
        end else begin
            r_q2_v <= r_q1_v;
        end
        r_q2_neg    <= r_q1_neg;
        r_q2_status <= r_q1_status;
        for (int i = 0; i < 3; i++) begin
            r_q2_sq[i] <= (SQW'(r_q1_hh[i]) << (2 * H2)) + (SQW'(r_q1_hl[i]) << (H2 + 1))
                        + SQW'(r_q1_ll[i]);
        end
    end

    logic [SW-1:0] q3_sum;
    assign q3_sum = SW'(r_q2_sq[0]) + SW'(r_q2_sq[1]) + SW'(r_q2_sq[2]);

    // ---------------- digit-by-digit square root, one root bit per stage ----------------
    logic             r_sq_v      [0:RTW];
    logic             r_sq_neg    [0:RTW];
    pld_pkg::t_status r_sq_status [0:RTW];
    logic [TW-1:0]    r_sq_t      [0:RTW];
    logic [RRW-1:0]   r_sq_rem    [0:RTW];
    logic [RTW-1:0]   r_sq_root   [0:RTW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else begin
            r_sq_v[0] <= r_q2_v;
        end
        r_sq_neg[0]    <= r_q2_neg;
        r_sq_status[0] <= r_q2_status;
        r_sq_t[0]      <= q3_sum[SW-1:2*U_FRAC_BITS];
        r_sq_rem[0]    <= '0;
        r_sq_root[0]   <= '0;
    end

    for (genvar j = 0; j < RTW; j++) begin : g_sqrt
        localparam int P = TW - 1 - 2 * j;
        logic [RRW-1:0] rem2;
        logic [RRW-1:0] trial;
        logic           ge;

        assign rem2  = {r_sq_rem[j][RRW-3:0], r_sq_t[j][P -: 2]};
        assign trial = {r_sq_root[j], 2'b01};
        assign ge    = rem2 >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[j+1] <= 1'b0;
            end else begin
                r_sq_v[j+1] <= r_sq_v[j];
            end
            r_sq_neg[j+1]    <= r_sq_neg[j];
            r_sq_status[j+1] <= r_sq_status[j];
            r_sq_t[j+1]      <= r_sq_t[j];
            r_sq_rem[j+1]    <= ge ? (rem2 - trial) : rem2;
            r_sq_root[j+1]   <= {r_sq_root[j][RTW-2:0], ge};
        end
    end

    // ---------------- saturate, sign, output register ----------------
    logic [MW-1:0]        mag_ext;
    logic [MW-1:0]        mag_sat;
    logic signed [OW-1:0] n_dist;

    assign mag_ext = MW'(r_sq_root[RTW]);
    assign mag_sat = (mag_ext > D_MAX) ? D_MAX : mag_ext;

    always_comb begin
        if (r_sq_status[RTW] != pld_pkg::ST_OK) begin
            n_dist = '0;
        end else if (r_sq_neg[RTW]) begin
            n_dist = -$signed(OW'(mag_sat));
        end else begin
            n_dist = $signed(OW'(mag_sat));
        end
    end

    logic                 r_out_v;
    logic signed [OW-1:0] r_out_dist;
    pld_pkg::t_status     r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_sq_v[RTW];
        end
        r_out_dist   <= n_dist;
        r_out_status <= r_sq_status[RTW];
    end

    assign o_valid    = r_out_v;
    assign o_dist_res = r_out_dist;
    assign o_status   = r_out_status;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    typedef logic signed [255:0] t_wide;
    typedef logic signed [31:0] t_coord;
    typedef logic signed [pld_pkg::DIST_WIDTH-1:0] t_dist;

    typedef struct {
        t_dist      dist_val;
        logic [1:0] status;
    } t_dist_result;

    typedef struct {
        logic [1:0]       mode;
        logic             sgn;
        t_coord           c [9];
        bit               typed;
        t_dist            dist_val;
        pld_pkg::t_status status;
    } t_query_row;

    localparam t_coord CMAX = 32'sh7FFF_FFFF;
    localparam t_coord CMIN = 32'sh8000_0000;
    localparam int     WATCHDOG_LIMIT = 5000;
    localparam int     PIPE_LATENCY   = 144;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    t_coord      i_line_ax = '0, i_line_ay = '0, i_line_az = '0;
    t_coord      i_line_bx = '0, i_line_by = '0, i_line_bz = '0;
    t_coord      i_query_x = '0, i_query_y = '0, i_query_z = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [pld_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [pld_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        o_valid;
    t_dist       o_dist_res;
    logic [1:0]  o_status;

    point_line_distance_3d_top dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow of the block's registers
    logic [1:0] cur_line_mode = pld_pkg::LM_INFINITE;
    logic       cur_signed    = 1'b0;

    t_dist_result pending_dist [$];
    bit           typed_now = 0;
    t_dist_result typed_val;
    int           errors = 0;
    int           watchdog = 0;
    int           n_items = 0;
    int           n_results = 0;
    int           n_degen = 0, n_outside = 0;

    function automatic t_wide isqrt_floor(t_wide x);
        t_wide res, b, t;
        res = '0;
        b = t_wide'(1) <<< 254;
        while (b != 0 && b > x) b = b >>> 2;
        while (b != 0) begin
            t = res + b;
            if (x >= t) begin
                x = x - t;
                res = (res >>> 1) + b;
            end else begin
                res = res >>> 1;
            end
            b = b >>> 2;
        end
        return res;
    endfunction

    function automatic t_dist_result predict_distance(t_coord c [9], logic [1:0] mode,
                                                      logic sgn);
        t_dist_result r;
        t_wide d [3], w [3], e [3], a, len2, dotp, u, one, s, root, mag, dmax;
        logic neg;
        for (int i = 0; i < 3; i++) begin
            a = t_wide'(c[i]);
            d[i] = t_wide'(c[3 + i]) - a;
            w[i] = t_wide'(c[6 + i]) - a;
        end
        r.dist_val = '0;
        if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
            r.status = pld_pkg::ST_DEGEN;
            return r;
        end
        len2 = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        dotp = w[0] * d[0] + w[1] * d[1] + w[2] * d[2];
        u = (dotp <<< 32) / len2;   // signed divide truncates toward zero
        one = t_wide'(1) <<< 32;
        if (mode == pld_pkg::LM_CHECKED && (u < 0 || u > one)) begin
            r.status = pld_pkg::ST_OUTSIDE;
            return r;
        end
        if (mode == pld_pkg::LM_CLAMP) begin
            if (u < 0) u = '0;
            else if (u > one) u = one;
        end
        s = '0;
        for (int i = 0; i < 3; i++) begin
            e[i] = (w[i] <<< 32) - u * d[i];
            s = s + e[i] * e[i];
        end
        root = isqrt_floor(s >>> 64);
        dmax = (t_wide'(1) <<< (pld_pkg::DIST_WIDTH - 1)) - 1;
        mag = (root > dmax) ? dmax : root;
        neg = 1'b0;
        if (sgn) begin
            if (d[0] > 0) neg = e[1] < 0;
            else if (d[0] < 0) neg = !(e[1] < 0);
            else neg = e[0] < 0;
        end
        r.dist_val = neg ? -mag[pld_pkg::DIST_WIDTH-1:0] : mag[pld_pkg::DIST_WIDTH-1:0];
        r.status = pld_pkg::ST_OK;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_coord c [9];
        t_dist_result exp_r;
        bit moved;
        moved = 0;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                c = '{i_line_ax, i_line_ay, i_line_az, i_line_bx, i_line_by, i_line_bz,
                      i_query_x, i_query_y, i_query_z};
                pending_dist.push_back(typed_now ? typed_val
                                       : predict_distance(c, cur_line_mode, cur_signed));
                n_items++;
                moved = 1;
            end
            if (o_valid) begin
                moved = 1;
                n_results++;
                if (o_status == pld_pkg::ST_DEGEN) n_degen++;
                if (o_status == pld_pkg::ST_OUTSIDE) n_outside++;
                if (pending_dist.size() == 0) begin
                    $error("unexpected result dist_res %0d status %0d", o_dist_res, o_status);
                    errors++;
                end else begin
                    exp_r = pending_dist.pop_front();
                    if (o_dist_res !== exp_r.dist_val) begin
                        $error("dist_res exp %0d got %0d", exp_r.dist_val, o_dist_res);
                        errors++;
                    end
                    if (o_status !== exp_r.status) begin
                        $error("status exp %0d got %0d", exp_r.status, o_status);
                        errors++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1;
                if (i_cfg_index == pld_pkg::CFG_LINE_MODE) cur_line_mode <= i_cfg_data[1:0];
                else if (i_cfg_index == pld_pkg::CFG_SIGNED_MODE) cur_signed <= i_cfg_data[0];
            end
        end
        watchdog = moved ? 0 : watchdog + 1;
        if (watchdog >= WATCHDOG_LIMIT) begin
            $display("timeout: no request or result for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL point_line_distance_3d_top");
            $finish;
        end
    end

    task automatic cfg_write(logic [pld_pkg::CFG_IDX_W-1:0] idx,
                             logic [pld_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain;
        while (pending_dist.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_modes(logic [1:0] mode, logic sgn);
        drain();
        // upper data bits are junk the block must mask off
        cfg_write(pld_pkg::CFG_LINE_MODE, {6'($urandom), mode});
        cfg_write(pld_pkg::CFG_SIGNED_MODE, {7'($urandom), sgn});
        if ($urandom_range(0, 1)) cfg_write(8'($urandom_range(2, 255)), 8'($urandom));
    endtask

    task automatic send_query(t_coord c [9], int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start = 1'b0;
            @(negedge i_clk);
        end
        i_start = 1'b1;
        {i_line_ax, i_line_ay, i_line_az} = {c[0], c[1], c[2]};
        {i_line_bx, i_line_by, i_line_bz} = {c[3], c[4], c[5]};
        {i_query_x, i_query_y, i_query_z} = {c[6], c[7], c[8]};
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
    endtask

    function automatic t_coord pick_edge();
        case ($urandom_range(0, 4))
            0: return CMIN;
            1: return CMAX;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    function automatic t_coord small_rand(int span);
        return t_coord'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic void random_query(ref t_coord c [9]);
        int k;
        case ($urandom_range(0, 9))
            0, 1: for (int i = 0; i < 9; i++) c[i] = t_coord'($urandom);
            2: begin
                for (int i = 0; i < 3; i++) begin
                    c[i] = t_coord'($urandom);
                    c[3 + i] = c[i];
                    c[6 + i] = t_coord'($urandom);
                end
            end
            3: for (int i = 0; i < 9; i++) c[i] = pick_edge();
            default: begin
                // query placed around the segment, u from -1 to 2
                k = $urandom_range(0, 12);
                for (int i = 0; i < 3; i++) begin
                    c[i] = small_rand(1 << 16);
                    c[3 + i] = c[i] + small_rand(1 << 12);
                    c[6 + i] = c[i] + ((c[3 + i] - c[i]) * (k - 4)) / 4 + small_rand(1 << 10);
                end
            end
        endcase
    endfunction

    t_query_row rows [$];

    task automatic add_row(logic [1:0] mode, logic sgn, t_coord c [9], bit typed,
                           t_dist dist_val, pld_pkg::t_status st);
        t_query_row r;
        r.mode = mode; r.sgn = sgn; r.c = c;
        r.typed = typed; r.dist_val = dist_val; r.status = st;
        rows.push_back(r);
    endtask

    localparam t_coord Z = 32'sd0;
    localparam t_coord U1 = 32'sd256;

    initial begin
        t_coord c [9];
        logic [1:0] modes [8];
        logic       sgns  [8];
        int         idles [8];
        logic [1:0] last_mode;
        logic       last_sgn;

        modes = '{pld_pkg::LM_INFINITE, pld_pkg::LM_CLAMP, pld_pkg::LM_CHECKED,
                  pld_pkg::LM_CHECKED, pld_pkg::LM_INFINITE, 2'd3, pld_pkg::LM_CLAMP,
                  pld_pkg::LM_CHECKED};
        sgns  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
        idles = '{0, 79, 14, 0, 79, 14, 0, 79};

        add_row(pld_pkg::LM_INFINITE, 1'b0, '{Z, Z, Z, Z, Z, Z, Z, Z, Z}, 1'b1, 36'sd0,
                pld_pkg::ST_DEGEN);
        add_row(pld_pkg::LM_INFINITE, 1'b0,
                '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN},
                1'b1, 36'sd0, pld_pkg::ST_DEGEN);
        add_row(pld_pkg::LM_INFINITE, 1'b0, '{Z, Z, Z, U1, Z, Z, Z, U1, Z}, 1'b1, 36'sd256,
                pld_pkg::ST_OK);
        add_row(pld_pkg::LM_INFINITE, 1'b0, '{Z, Z, Z, U1, Z, Z, Z, -U1, Z}, 1'b1, 36'sd256,
                pld_pkg::ST_OK);
        add_row(pld_pkg::LM_INFINITE, 1'b0, '{Z, Z, Z, U1, Z, Z, 4 * U1, Z, Z}, 1'b1, 36'sd0,
                pld_pkg::ST_OK);
        add_row(pld_pkg::LM_INFINITE, 1'b0,
                '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, Z},
                1'b0, 36'sd0, pld_pkg::ST_OK);
        add_row(pld_pkg::LM_INFINITE, 1'b0,
                '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN},
                1'b0, 36'sd0, pld_pkg::ST_OK);
        add_row(pld_pkg::LM_INFINITE, 1'b1, '{Z, Z, Z, U1, Z, Z, Z, -U1, Z}, 1'b1, -36'sd256,
                pld_pkg::ST_OK);
        add_row(pld_pkg::LM_INFINITE, 1'b1, '{Z, Z, Z, -U1, Z, Z, Z, -U1, Z}, 1'b1, 36'sd256,
                pld_pkg::ST_OK);
        add_row(pld_pkg::LM_INFINITE, 1'b1, '{Z, Z, Z, Z, U1, Z, -U1, Z, Z}, 1'b1, -36'sd256,
                pld_pkg::ST_OK);
        add_row(pld_pkg::LM_INFINITE, 1'b1,
                '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX},
                1'b0, 36'sd0, pld_pkg::ST_OK);
        add_row(pld_pkg::LM_CHECKED, 1'b0, '{Z, Z, Z, U1, Z, Z, 2 * U1, U1, Z}, 1'b1, 36'sd0,
                pld_pkg::ST_OUTSIDE);
        add_row(pld_pkg::LM_CHECKED, 1'b0, '{Z, Z, Z, U1, Z, Z, -32'sd1, Z, Z}, 1'b1, 36'sd0,
                pld_pkg::ST_OUTSIDE);
        add_row(pld_pkg::LM_CHECKED, 1'b0, '{Z, Z, Z, U1, Z, Z, U1 / 2, U1, Z}, 1'b1,
                36'sd256, pld_pkg::ST_OK);
        add_row(pld_pkg::LM_CHECKED, 1'b0, '{Z, Z, Z, U1, Z, Z, U1, U1, Z}, 1'b1, 36'sd256,
                pld_pkg::ST_OK);
        add_row(pld_pkg::LM_CHECKED, 1'b0, '{Z, Z, Z, Z, Z, Z, U1, U1, Z}, 1'b1, 36'sd0,
                pld_pkg::ST_DEGEN);
        add_row(pld_pkg::LM_CLAMP, 1'b1, '{Z, Z, Z, U1, Z, Z, 2 * U1, U1, Z}, 1'b0, 36'sd0,
                pld_pkg::ST_OK);
        add_row(pld_pkg::LM_CLAMP, 1'b1, '{Z, Z, Z, U1, Z, Z, -2 * U1, -U1, Z}, 1'b0, 36'sd0,
                pld_pkg::ST_OK);
        add_row(pld_pkg::LM_CLAMP, 1'b0, '{CMIN, CMAX, Z, CMAX, CMIN, Z, CMAX, CMAX, CMAX},
                1'b0, 36'sd0, pld_pkg::ST_OK);
        add_row(2'd3, 1'b0, '{Z, Z, Z, U1, Z, Z, 2 * U1, U1, Z}, 1'b1, 36'sd256,
                pld_pkg::ST_OK);

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        last_mode = pld_pkg::LM_INFINITE;
        last_sgn  = 1'b0;
        foreach (rows[i]) begin
            if (rows[i].mode != last_mode || rows[i].sgn != last_sgn) begin
                i_start = 1'b0;
                set_modes(rows[i].mode, rows[i].sgn);
                last_mode = rows[i].mode;
                last_sgn  = rows[i].sgn;
            end
            typed_now = rows[i].typed;
            typed_val.dist_val = rows[i].dist_val;
            typed_val.status = rows[i].status;
            send_query(rows[i].c, 0);
        end
        typed_now = 0;
        i_start = 1'b0;

        for (int p = 0; p < 8; p++) begin
            set_modes(modes[p], sgns[p]);
            for (int n = 0; n < 190; n++) begin
                random_query(c);
                send_query(c, idles[p]);
                // one full pause mid-phase until every result is back
                if (p == 3 && n == 95) begin
                    i_start = 1'b0;
                    drain();
                end
            end
            i_start = 1'b0;
        end

        drain();
        repeat (PIPE_LATENCY + 16) @(negedge i_clk);
        if (pending_dist.size() != 0) begin
            $error("%0d expected results never arrived", pending_dist.size());
            errors++;
        end
        $display("covered %0d queries, %0d results (%0d degenerate, %0d outside)",
                 n_items, n_results, n_degen, n_outside);
        $display("line modes 0-3, both sign modes, sender gaps of 0/14/79 percent");
        if (errors == 0) begin
            $display("PASS point_line_distance_3d_top");
        end else begin
            $display("FAIL point_line_distance_3d_top");
        end
        $finish;
    end

endmodule
